[sv/string_escape_decoder_core_defines.svh]
// Assertion helpers shared by the string escape decoder.
`ifndef STRING_ESCAPE_DECODER_CORE_DEFINES_SVH
`define STRING_ESCAPE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("string escape decoder: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("string escape decoder: next-cycle check failed");

`endif

[sv/sed_pkg.sv]
`timescale 1ns / 1ps

package sed_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] bad_char;
  } out_t;

  // Decoder result for one character: whether it yields a result, and the result.
  typedef struct packed {
    logic has_res;
    out_t rsp;
  } step_t;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESC    = 4'b0010,
    MODE_HEX1   = 4'b0100,
    MODE_HEX2   = 4'b1000
  } mode_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_ESC  = 2'd1,
    ERR_HEX  = 2'd2
  } err_e;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF_HEX = 8'h46;

  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_CR  = 8'h0D;

  // Return {digit ok, digit value} for one hex character in either case.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    v  = 8'h00;
    ok = 1'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v  = c - CH_ZERO;
      ok = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      v  = c - CH_LA + 8'd10;
      ok = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF_HEX) begin
      v  = c - CH_UA + 8'd10;
      ok = 1'b1;
    end
    return {ok, v[3:0]};
  endfunction

endpackage

[sv/sed_decode.sv]
`timescale 1ns / 1ps

module sed_decode import sed_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   req_i,
  input  logic  advance_i,
  output step_t step_o
);

  mode_e      mode_q, mode_d;
  logic [2:0] hex_q, hex_d;
  logic       trunc_q, trunc_d;
  err_e       err_q, err_d;
  logic [7:0] ech_q, ech_d;

  always_comb begin
    logic [7:0] c;
    logic [4:0] hd;
    logic       emit;
    logic [7:0] byte_v;
    c       = req_i.in_char;
    hd      = hex_digit(c);
    emit    = 1'b0;
    byte_v  = 8'h00;
    mode_d  = mode_q;
    hex_d   = hex_q;
    trunc_d = trunc_q;
    err_d   = err_q;
    ech_d   = ech_q;

    unique case (mode_q)
      MODE_NORMAL: begin
        if (c == CH_BSLASH) begin
          mode_d = MODE_ESC;
        end else begin
          emit   = 1'b1;
          byte_v = c;
        end
      end
      MODE_ESC: begin
        mode_d = MODE_NORMAL;
        priority if (c == CH_N) begin
          emit   = 1'b1;
          byte_v = BYTE_LF;
        end else if (c == CH_T) begin
          emit   = 1'b1;
          byte_v = BYTE_TAB;
        end else if (c == CH_R) begin
          emit   = 1'b1;
          byte_v = BYTE_CR;
        end else if (c == CH_BSLASH || c == CH_QUOTE) begin
          emit   = 1'b1;
          byte_v = c;
        end else if (c == CH_ZERO) begin
          trunc_d = 1'b1;
        end else if (c == CH_X) begin
          mode_d = MODE_HEX1;
        end else begin
          if (err_d == ERR_NONE) begin
            err_d = ERR_ESC;
            ech_d = c;
          end
        end
      end
      MODE_HEX1: begin
        mode_d = MODE_HEX2;
        if (c >= CH_ZERO && c <= CH_SEVEN) begin
          hex_d = c[2:0];
        end else begin
          hex_d = 3'd0;
          if (err_d == ERR_NONE) begin
            err_d = ERR_HEX;
            ech_d = 8'h00;
          end
        end
      end
      MODE_HEX2: begin
        mode_d = MODE_NORMAL;
        if (!hd[4]) begin
          if (err_d == ERR_NONE) begin
            err_d = ERR_HEX;
            ech_d = 8'h00;
          end
        end else begin
          byte_v = {1'b0, hex_q, hd[3:0]};
          if (byte_v == 8'h00) trunc_d = 1'b1;
          else                 emit    = 1'b1;
        end
      end
      default: mode_d = MODE_NORMAL;
    endcase

    // Suppress output once truncated or in error.
    if (trunc_d || err_d != ERR_NONE) emit = 1'b0;
    if (!emit) byte_v = 8'h00;

    // Literal ends inside an escape.
    if (req_i.is_last && err_d == ERR_NONE) begin
      if (mode_d == MODE_ESC) begin
        err_d = ERR_ESC;
        ech_d = 8'h00;
      end else if (mode_d != MODE_NORMAL) begin
        err_d = ERR_HEX;
        ech_d = 8'h00;
      end
    end

    step_o.has_res         = emit || req_i.is_last;
    step_o.rsp.byte_valid  = emit;
    step_o.rsp.out_byte    = byte_v;
    step_o.rsp.done_res    = req_i.is_last;
    step_o.rsp.status      = req_i.is_last ? err_d : ERR_NONE;
    step_o.rsp.bad_char    = (req_i.is_last && err_d == ERR_ESC) ? ech_d : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      hex_q   <= 3'd0;
      trunc_q <= 1'b0;
      err_q   <= ERR_NONE;
      ech_q   <= 8'h00;
    end else if (advance_i) begin
      if (req_i.is_last) begin
        mode_q  <= MODE_NORMAL;
        hex_q   <= 3'd0;
        trunc_q <= 1'b0;
        err_q   <= ERR_NONE;
        ech_q   <= 8'h00;
      end else begin
        mode_q  <= mode_d;
        hex_q   <= hex_d;
        trunc_q <= trunc_d;
        err_q   <= err_d;
        ech_q   <= ech_d;
      end
    end
  end

endmodule

[sv/sed_out_reg.sv]
`timescale 1ns / 1ps

module sed_out_reg import sed_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  out_t data_i,
  output logic free_o,
  output logic valid_o,
  input  logic ready_i,
  output out_t data_o
);

  logic vld_q, vld_d;
  out_t data_q;

  assign free_o  = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i)       vld_d = 1'b1;
    else if (ready_i) vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload holds until the next load.
  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_i;
  end

endmodule

[sv/string_escape_decoder_core.sv]
`timescale 1ns / 1ps

// String literal escape decoder. Takes one body character per request (quotes
// stripped, is_last on the final one) and returns decoded bytes for \n \t \r
// \\ \" and \xHH (first digit 0-7). \0 and \x00 truncate: later characters
// are still checked but yield no byte. The first error is kept and reported
// in status/bad_char on the result of the last character; bytes of a string
// that ends with a nonzero status are to be discarded. A character that
// produces neither a byte nor the end of the string gives no result.
// Throughput is one request per clock while the output side does not stall; a
// result passes from the input register through the decode logic into the
// output register. The decode state advances only as a request leaves the input
// register, and in_ready_o drops only while both registers hold work and the
// output side stalls.

`include "string_escape_decoder_core_defines.svh"

module string_escape_decoder_core import sed_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_rsp_o
);

  // Input register
  logic  in_vld_q, in_vld_d;
  in_t   in_q;

  step_t step;
  logic  out_free;
  logic  advance;

  // Advance the held request when it needs no output slot or one is free.
  assign advance    = in_vld_q && (!step.has_res || out_free);
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) in_vld_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_req_i;
  end

  // Decode logic and per-string state
  sed_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (in_q),
    .advance_i (advance),
    .step_o    (step)
  );

  // Result register
  sed_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && step.has_res),
    .data_i  (step.rsp),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_rsp_o)
  );

  // Every result carries a byte or closes a string.
  `SED_ASSERT_IMP(a_no_empty_rsp, out_valid_o, out_rsp_o.byte_valid || out_rsp_o.done_res)
  // Status and bad character appear only on the closing result.
  `SED_ASSERT_IMP(a_status_on_done, out_valid_o && !out_rsp_o.done_res,
                  out_rsp_o.status == ERR_NONE && out_rsp_o.bad_char == 8'h00)
  // A bad character is reported only with an undefined escape.
  `SED_ASSERT_IMP(a_bad_char_esc, out_valid_o && out_rsp_o.status != ERR_ESC,
                  out_rsp_o.bad_char == 8'h00)
  // An accepted request lands in the input register.
  `SED_ASSERT_NXT(a_in_capture, in_valid_i && in_ready_o, in_vld_q)

endmodule
